// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked check that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/mpm_pkg.sv -----
package mpm_pkg;

  localparam int NODES      = 256;
  localparam int ALPHABET   = 26;
  localparam int NODE_W     = $clog2(NODES);
  localparam int SYM_W      = 5;
  localparam int EDGE_W     = NODE_W + 1;
  localparam int EDGE_DEPTH = NODES * ALPHABET;
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int CNT_W      = 9;
  localparam int COUNT_MAX  = 256;
  localparam int TOTAL_W    = 32;
  localparam int OUT_DATA_W = 56;
  localparam logic [EDGE_W-1:0] ABSENT = EDGE_W'(NODES);

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_BUILD   = 2'd1,
    CMD_SCAN    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOBUILD = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SC_E,
    ST_SC_N,
    ST_AD_E,
    ST_AD_N,
    ST_B_NEXT,
    ST_B_VGET,
    ST_B_VREAD,
    ST_B_VWORD,
    ST_B_LKWORD,
    ST_B_EV,
    ST_B_EL,
    ST_B_EN,
    ST_B_EC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic [SYM_W-1:0]  psym;
    logic [NODE_W-1:0] link;
    logic [CNT_W-1:0]  endc;
    logic [CNT_W-1:0]  chain;
  } node_word_t;

  localparam int NODE_WORD_W = $bits(node_word_t);

  typedef struct packed {
    logic               we;
    logic [EDGE_AW-1:0] waddr;
    logic [EDGE_W-1:0]  wdata;
    logic [EDGE_AW-1:0] raddr;
  } edge_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    node_word_t        wdata;
    logic [NODE_W-1:0] raddr;
  } node_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic [NODE_W-1:0] raddr;
  } queue_req_t;

  typedef struct packed {
    logic               valid;
    logic [NODE_W-1:0]  node;
    logic [CNT_W-1:0]   here;
    logic [TOTAL_W-1:0] total;
    status_t            status;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > (CNT_W+1)'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : s[CNT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/mpm_ram.sv -----
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/mpm_ctrl.sv -----
module mpm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mpm_pkg::cmd_t              in_cmd,
  input  logic [mpm_pkg::SYM_W-1:0]  in_sym,
  input  logic                       in_last,
  output mpm_pkg::result_t           res,
  input  logic                       res_ready,
  output mpm_pkg::edge_req_t         edge_req,
  input  logic [mpm_pkg::EDGE_W-1:0] edge_rdata,
  output mpm_pkg::node_req_t         node_req,
  input  mpm_pkg::node_word_t        node_rdata,
  output mpm_pkg::queue_req_t        queue_req,
  input  logic [mpm_pkg::NODE_W-1:0] queue_rdata
);
  import mpm_pkg::*;

  state_t state, state_next;

  logic [EDGE_AW-1:0] clr;
  logic [NODE_W:0]    node_count;
  logic [NODE_W-1:0]  ins_cur;
  logic [NODE_W-1:0]  scan_cur;
  logic [TOTAL_W-1:0] total;
  logic               built;

  logic [SYM_W-1:0]   sym_q;
  logic               last_q;
  logic [EDGE_AW-1:0] addr_q;
  logic [EDGE_W-1:0]  ent_q;
  logic [NODE_W-1:0]  nxt_q;
  logic [NODE_W-1:0]  v_q;
  logic [NODE_W-1:0]  lk_q;
  logic [NODE_W-1:0]  via_q;
  node_word_t         vword_q;
  logic [SYM_W-1:0]   c_q;
  logic               is_root;
  logic [NODE_W:0]    head;
  logic [NODE_W:0]    tail;

  logic [NODE_W-1:0]  res_node;
  logic [CNT_W-1:0]   res_here;
  status_t            res_status;

  logic               in_fire;
  logic               sym_ok;
  logic [EDGE_AW-1:0] in_addr;
  logic [NODE_W-1:0]  nxt_comb;
  logic [NODE_W-1:0]  lk_comb;
  logic               add_trie;
  logic               bld_trie;
  logic               nodes_left;
  logic               tail_room;
  logic [TOTAL_W:0]   tsum;

  function automatic logic [EDGE_AW-1:0] edge_addr(input logic [NODE_W-1:0] n,
                                                   input logic [SYM_W-1:0] s);
    return EDGE_AW'(int'(n) * ALPHABET + int'(s));
  endfunction

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign sym_ok     = int'(in_sym) < ALPHABET;
  assign in_addr    = edge_addr((in_cmd == CMD_SCAN) ? scan_cur : ins_cur, in_sym);
  assign nxt_comb   = (edge_rdata >= ABSENT) ? '0 : edge_rdata[NODE_W-1:0];
  assign lk_comb    = is_root ? '0 : node_rdata.link;
  assign add_trie   = (ent_q != ABSENT) && (ent_q != '0) &&
                      (node_rdata.parent == ins_cur) && (node_rdata.psym == sym_q);
  assign bld_trie   = (ent_q != ABSENT) && (ent_q != '0) &&
                      (node_rdata.parent == v_q) && (node_rdata.psym == c_q);
  assign nodes_left = int'(node_count) < NODES;
  assign tail_room  = int'(tail) < NODES;
  assign tsum       = {1'b0, total} + (TOTAL_W+1)'(node_rdata.chain);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == EDGE_AW'(EDGE_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_ADD:     state_next = sym_ok ? ST_AD_E : ST_FIN;
            CMD_BUILD:   state_next = ST_B_VREAD;
            CMD_SCAN:    state_next = (built && sym_ok) ? ST_SC_E : ST_FIN;
            CMD_RESTART: state_next = ST_FIN;
          endcase
        end
      end
      ST_SC_E:     state_next = ST_SC_N;
      ST_SC_N:     state_next = ST_FIN;
      ST_AD_E:     state_next = ST_AD_N;
      ST_AD_N:     state_next = ST_FIN;
      ST_B_NEXT:   state_next = (head == tail) ? ST_FIN : ST_B_VGET;
      ST_B_VGET:   state_next = ST_B_VREAD;
      ST_B_VREAD:  state_next = ST_B_VWORD;
      ST_B_VWORD:  state_next = ST_B_LKWORD;
      ST_B_LKWORD: state_next = ST_B_EV;
      ST_B_EV:     state_next = ST_B_EL;
      ST_B_EL:     state_next = ST_B_EN;
      ST_B_EN:     state_next = ST_B_EC;
      ST_B_EC: begin
        state_next = (int'(c_q) == ALPHABET - 1) ? ST_B_NEXT : ST_B_EV;
      end
      ST_FIN: begin
        if (res_ready) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    edge_req  = '0;
    node_req  = '0;
    queue_req = '0;
    unique case (state)
      ST_CLEAR: begin
        edge_req.we    = 1'b1;
        edge_req.waddr = clr;
        edge_req.wdata = ABSENT;
        node_req.we    = int'(clr) < NODES;
        node_req.waddr = clr[NODE_W-1:0];
      end
      ST_IDLE: edge_req.raddr = in_addr;
      ST_SC_E: node_req.raddr = nxt_comb;
      ST_AD_E: node_req.raddr = edge_rdata[NODE_W-1:0];
      ST_AD_N: begin
        if (add_trie) begin
          if (last_q) begin
            node_req.we         = 1'b1;
            node_req.waddr      = ent_q[NODE_W-1:0];
            node_req.wdata      = node_rdata;
            node_req.wdata.endc = sat_count(node_rdata.endc, CNT_W'(1));
          end
        end else if (nodes_left) begin
          edge_req.we           = 1'b1;
          edge_req.waddr        = addr_q;
          edge_req.wdata        = node_count;
          node_req.we           = 1'b1;
          node_req.waddr        = node_count[NODE_W-1:0];
          node_req.wdata.parent = ins_cur;
          node_req.wdata.psym   = sym_q;
          node_req.wdata.endc   = CNT_W'(last_q);
        end
      end
      ST_B_NEXT:  queue_req.raddr = head[NODE_W-1:0];
      ST_B_VREAD: node_req.raddr = v_q;
      ST_B_VWORD: node_req.raddr = lk_comb;
      ST_B_LKWORD: begin
        node_req.we          = 1'b1;
        node_req.waddr       = v_q;
        node_req.wdata       = vword_q;
        node_req.wdata.chain = sat_count(vword_q.endc, is_root ? '0 : node_rdata.chain);
      end
      ST_B_EV: edge_req.raddr = edge_addr(v_q, c_q);
      ST_B_EL: edge_req.raddr = edge_addr(lk_q, c_q);
      ST_B_EN: node_req.raddr = ent_q[NODE_W-1:0];
      ST_B_EC: begin
        if (bld_trie) begin
          node_req.we         = 1'b1;
          node_req.waddr      = ent_q[NODE_W-1:0];
          node_req.wdata      = node_rdata;
          node_req.wdata.link = via_q;
          queue_req.we        = tail_room;
          queue_req.waddr     = tail[NODE_W-1:0];
          queue_req.wdata     = ent_q[NODE_W-1:0];
        end else begin
          edge_req.we    = 1'b1;
          edge_req.waddr = edge_addr(v_q, c_q);
          edge_req.wdata = {1'b0, via_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      node_count <= (NODE_W+1)'(1);
      ins_cur    <= '0;
      scan_cur   <= '0;
      total      <= '0;
      built      <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: clr <= clr + EDGE_AW'(1);
        ST_IDLE: begin
          if (in_fire) begin
            sym_q      <= in_sym;
            last_q     <= in_last;
            addr_q     <= in_addr;
            res_here   <= '0;
            res_status <= (in_cmd == CMD_SCAN && !built) ? STAT_NOBUILD : STAT_OK;
            unique case (in_cmd)
              CMD_ADD: begin
                built    <= 1'b0;
                res_node <= ins_cur;
              end
              CMD_BUILD: begin
                res_node <= scan_cur;
                v_q      <= '0;
                is_root  <= 1'b1;
                head     <= '0;
                tail     <= '0;
              end
              CMD_SCAN: begin
                res_node <= scan_cur;
              end
              CMD_RESTART: begin
                scan_cur <= '0;
                total    <= '0;
                res_node <= '0;
              end
            endcase
          end
        end
        ST_SC_E: nxt_q <= nxt_comb;
        ST_SC_N: begin
          scan_cur <= nxt_q;
          res_node <= nxt_q;
          res_here <= node_rdata.chain;
          total    <= tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
        end
        ST_AD_E: ent_q <= edge_rdata;
        ST_AD_N: begin
          if (add_trie) begin
            res_node <= ent_q[NODE_W-1:0];
            ins_cur  <= last_q ? '0 : ent_q[NODE_W-1:0];
          end else if (nodes_left) begin
            res_node   <= node_count[NODE_W-1:0];
            ins_cur    <= last_q ? '0 : node_count[NODE_W-1:0];
            node_count <= node_count + (NODE_W+1)'(1);
          end else begin
            res_status <= STAT_FULL;
            if (last_q) ins_cur <= '0;
          end
        end
        ST_B_NEXT: begin
          if (head != tail) head <= head + (NODE_W+1)'(1);
          else built <= 1'b1;
        end
        ST_B_VGET: v_q <= queue_rdata;
        ST_B_VWORD: begin
          vword_q <= node_rdata;
          lk_q    <= lk_comb;
        end
        ST_B_LKWORD: c_q <= '0;
        ST_B_EL: ent_q <= edge_rdata;
        ST_B_EN: via_q <= is_root ? '0 : edge_rdata[NODE_W-1:0];
        ST_B_EC: begin
          if (bld_trie && tail_room) tail <= tail + (NODE_W+1)'(1);
          c_q <= c_q + SYM_W'(1);
          if (int'(c_q) == ALPHABET - 1) is_root <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.valid  = (state == ST_FIN);
    res.node   = res_node;
    res.here   = res_here;
    res.total  = total;
    res.status = res_status;
  end

endmodule

// ----- hw/rtl/multi_pattern_matcher_unit.sv -----
// Input transfer to m_tvalid: a scan reads the edge memory, then the node memory,
// and an add does the same; restart and rejected items go straight to the result;
// build processes every trie node, root included, in breadth-first order. One item at a time.
// Reset: synchronous; then a clearing pass over the edge memory (node memory
// zeroed at its 256 addresses during the pass) before s_tready rises.
module multi_pattern_matcher_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // symbol[4:0], zero pad
  input  logic [1:0]                     s_tuser,   // command[1:0]
  input  logic                           s_tlast,   // pattern_end
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mpm_pkg::OUT_DATA_W-1:0] m_tdata,   // node[7:0], matches_here[16:8],
                                                    // total_matches[48:17], zero pad
  output logic [1:0]                     m_tuser    // status[1:0]
);
  import mpm_pkg::*;

  edge_req_t           edge_req;
  node_req_t           node_req;
  queue_req_t          queue_req;
  logic [EDGE_W-1:0]   edge_rdata;
  logic [NODE_WORD_W-1:0] node_rdata;
  logic [NODE_W-1:0]   queue_rdata;
  result_t             res;
  logic                res_ready;

  assign res_ready = !m_tvalid || m_tready;

  mpm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (cmd_t'(s_tuser)),
    .in_sym      (s_tdata[SYM_W-1:0]),
    .in_last     (s_tlast),
    .res         (res),
    .res_ready   (res_ready),
    .edge_req    (edge_req),
    .edge_rdata  (edge_rdata),
    .node_req    (node_req),
    .node_rdata  (node_word_t'(node_rdata)),
    .queue_req   (queue_req),
    .queue_rdata (queue_rdata)
  );

  mpm_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk   (clk),
    .we    (edge_req.we),
    .waddr (edge_req.waddr),
    .wdata (edge_req.wdata),
    .raddr (edge_req.raddr),
    .rdata (edge_rdata)
  );

  mpm_ram #(.WIDTH(NODE_WORD_W), .DEPTH(NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_req.we),
    .waddr (node_req.waddr),
    .wdata (node_req.wdata),
    .raddr (node_req.raddr),
    .rdata (node_rdata)
  );

  mpm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue_ram (
    .clk   (clk),
    .we    (queue_req.we),
    .waddr (queue_req.waddr),
    .wdata (queue_req.wdata),
    .raddr (queue_req.raddr),
    .rdata (queue_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_tdata <= OUT_DATA_W'({res.total, res.here, res.node});
      m_tuser <= res.status;
    end
  end

endmodule

// ----- hw/rtl/mpm_checker.sv -----
`include "assert_macros.svh"

module mpm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [7:0]                     s_tdata,
  input logic [1:0]                     s_tuser,
  input logic                           s_tlast,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mpm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser
);
  import mpm_pkg::*;

  // clearing pass keeps input closed right after reset
  `ASSERT_ALWAYS(a_clear_after_rst, clk, $past(rst) |-> !s_tready)

  // one item in flight: busy after an input transfer
  `ASSERT_CLK(a_busy_after_in, clk, rst, (s_tvalid && s_tready) |=> !s_tready)

  // items with an error status report no matches
  `ASSERT_CLK(a_err_no_match, clk, rst, (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata[16:8] == '0))

  // held result stays put
  `ASSERT_CLK(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

bind multi_pattern_matcher_unit mpm_checker u_mpm_checker (.*);

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpm_pkg::*;

  typedef struct {
    logic [7:0]  node;
    logic [8:0]  here;
    logic [31:0] total;
    status_t     status;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  multi_pattern_matcher_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [8:0] trie_next [NODES*ALPHABET];
  int link_of [NODES];
  int parent_of [NODES];
  int psym_of [NODES];
  int ends_at [NODES];
  int chain_hits [NODES];
  int nodes_used, ins_node, scan_node;
  logic [31:0] run_total;
  bit built;

  step_result_t pending_results [$];
  int errors, sent_items, checked_results, match_steps, builds_done;
  bit idle_on;
  bit took;
  int stall = 0;

  function automatic int sat256(int a, int b);
    return (a + b > COUNT_MAX) ? COUNT_MAX : a + b;
  endfunction

  function automatic bit is_child(int v, int c);
    int e;
    e = int'(trie_next[v*ALPHABET + c]);
    return e != NODES && e != 0 && e < NODES && parent_of[e] == v && psym_of[e] == c;
  endfunction

  task automatic build_automaton();
    int bfs [$];
    int v, lk, u;
    logic [8:0] via;
    link_of[0] = 0;
    chain_hits[0] = ends_at[0];
    for (int c = 0; c < ALPHABET; c++) begin
      if (is_child(0, c)) begin
        u = int'(trie_next[c]);
        link_of[u] = 0;
        bfs.insert(bfs.size(), u);
      end else trie_next[c] = '0;
    end
    while (bfs.size() > 0) begin
      v = bfs.pop_front();
      lk = link_of[v];
      chain_hits[v] = sat256(ends_at[v], chain_hits[lk]);
      for (int c = 0; c < ALPHABET; c++) begin
        via = trie_next[lk*ALPHABET + c];
        if (is_child(v, c)) begin
          u = int'(trie_next[v*ALPHABET + c]);
          link_of[u] = int'(via);
          bfs.insert(bfs.size(), u);
        end else trie_next[v*ALPHABET + c] = via;
      end
    end
    built = 1'b1;
  endtask

  task automatic predict_step(cmd_t cmd, int sym, bit last);
    step_result_t r;
    int nxt;
    r.node = 8'(scan_node);
    r.here = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_ADD: begin
        built = 1'b0;
        r.node = 8'(ins_node);
        if (sym < ALPHABET) begin
          if (is_child(ins_node, sym)) r.node = trie_next[ins_node*ALPHABET + sym][7:0];
          else if (nodes_used < NODES) begin
            r.node = 8'(nodes_used);
            trie_next[ins_node*ALPHABET + sym] = 9'(nodes_used);
            parent_of[nodes_used] = ins_node;
            psym_of[nodes_used] = sym;
            nodes_used++;
          end else r.status = STAT_FULL;
          if (r.status == STAT_OK) begin
            if (last) begin
              ends_at[r.node] = sat256(ends_at[r.node], 1);
              ins_node = 0;
            end else ins_node = int'(r.node);
          end else if (last) ins_node = 0;
        end
      end
      CMD_BUILD: begin
        build_automaton();
        builds_done++;
        r.node = 8'(scan_node);
      end
      CMD_SCAN: begin
        if (!built) r.status = STAT_NOBUILD;
        else if (sym < ALPHABET) begin
          nxt = int'(trie_next[scan_node*ALPHABET + sym]);
          if (nxt >= NODES) nxt = 0;
          scan_node = nxt;
          r.here = 9'(chain_hits[nxt]);
          if (r.here != 0) match_steps++;
          run_total = (run_total > 32'hFFFF_FFFF - r.here) ? 32'hFFFF_FFFF
                                                            : run_total + r.here;
        end
        r.node = 8'(scan_node);
      end
      default: begin
        scan_node = 0;
        run_total = '0;
        r.node = '0;
      end
    endcase
    r.total = run_total;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic send_item(cmd_t cmd, int sym, bit last);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {3'b000, sym[4:0]};
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_step(cmd, sym, last);
    sent_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic add_pattern(int len, int span);
    for (int i = 0; i < len; i++) send_item(CMD_ADD, $urandom_range(0, span), i == len - 1);
  endtask

  // result check
  always @(posedge clk) begin
    step_result_t e;
    took = 1'b0;
    if (!rst && m_tvalid && m_tready) begin
      took = 1'b1;
      checked_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[7:0] !== e.node) begin
          $error("node exp %0d got %0d", e.node, m_tdata[7:0]); errors++;
        end
        if (m_tdata[16:8] !== e.here) begin
          $error("matches_here exp %0d got %0d", e.here, m_tdata[16:8]); errors++;
        end
        if (m_tdata[48:17] !== e.total) begin
          $error("total_matches exp %0d got %0d", e.total, m_tdata[48:17]); errors++;
        end
        if (m_tuser !== e.status) begin
          $error("status exp %0d got %0d", e.status, m_tuser); errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (took) stall = idle_on ? $urandom_range(0, 4) : 0;
    if (stall > 0) begin
      m_tready <= 1'b0;
      stall--;
    end else m_tready <= 1'b1;
  end

  task automatic test_basics();
    idle_on = 1'b0;
    send_item(CMD_SCAN, 3, 0);
    send_item(CMD_ADD, 26, 1);
    send_item(CMD_ADD, 31, 0);
    add_pattern(1, 0);
    send_item(CMD_ADD, 1, 0);
    send_item(CMD_ADD, 25, 1);
    send_item(CMD_ADD, 25, 1);
    send_item(CMD_BUILD, 0, 0);
    send_item(CMD_SCAN, 0, 0);
    send_item(CMD_SCAN, 1, 1);
    send_item(CMD_SCAN, 25, 0);
    send_item(CMD_SCAN, 31, 0);
    send_item(CMD_SCAN, 26, 0);
    send_item(CMD_SCAN, 25, 0);
    send_item(CMD_RESTART, 31, 1);
    send_item(CMD_SCAN, 25, 0);
    send_item(CMD_ADD, 1, 0);
    send_item(CMD_SCAN, 0, 0);
    send_item(CMD_ADD, 2, 1);
    send_item(CMD_BUILD, 5, 1);
    send_item(CMD_SCAN, 1, 0);
    send_item(CMD_SCAN, 2, 0);
    drain();
  endtask

  task automatic test_end_saturation();
    idle_on = 1'b1;
    for (int i = 0; i < 258; i++) send_item(CMD_ADD, 0, 1);
    send_item(CMD_ADD, 0, 0);
    send_item(CMD_ADD, 0, 1);
    send_item(CMD_BUILD, 0, 0);
    send_item(CMD_RESTART, 0, 0);
    for (int i = 0; i < 6; i++) send_item(CMD_SCAN, 0, 0);
    drain();
  endtask

  task automatic test_random_text();
    int span;
    for (int round = 0; round < 8; round++) begin
      idle_on = $urandom_range(0, 3) != 0;
      span = (round % 3 == 0) ? 31 : 3;
      for (int p = 0; p < 4; p++) add_pattern($urandom_range(1, 4), span);
      send_item(CMD_BUILD, $urandom_range(0, 31), $urandom_range(0, 1));
      for (int i = 0; i < 80; i++) begin
        case ($urandom_range(0, 19))
          0: send_item(CMD_RESTART, $urandom_range(0, 31), $urandom_range(0, 1));
          1: send_item(CMD_SCAN, $urandom_range(0, 31), $urandom_range(0, 1));
          default: send_item(CMD_SCAN, $urandom_range(0, 4), $urandom_range(0, 1));
        endcase
      end
      if (round == 3) drain();
    end
    drain();
  endtask

  task automatic test_table_full();
    idle_on = 1'b1;
    while (nodes_used < NODES) add_pattern(6, 25);
    send_item(CMD_ADD, 7, 0);
    send_item(CMD_ADD, 9, 1);
    add_pattern(3, 25);
    send_item(CMD_BUILD, 0, 0);
    send_item(CMD_RESTART, 0, 0);
    for (int i = 0; i < 80; i++) send_item(CMD_SCAN, $urandom_range(0, 25), 0);
    drain();
  endtask

  initial begin
    for (int i = 0; i < NODES*ALPHABET; i++) trie_next[i] = 9'(NODES);
    for (int i = 0; i < NODES; i++) begin
      link_of[i] = 0; parent_of[i] = 0; psym_of[i] = 0; ends_at[i] = 0; chain_hits[i] = 0;
    end
    nodes_used = 1; ins_node = 0; scan_node = 0; run_total = '0; built = 1'b0;
    errors = 0; sent_items = 0; checked_results = 0; match_steps = 0; builds_done = 0;
    idle_on = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_basics();
    test_end_saturation();
    test_random_text();
    test_table_full();
    repeat (30) @(posedge clk);
    if (pending_results.size() > 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("Ran %0d items, %0d builds, %0d result transfers checked;", sent_items,
             builds_done, checked_results);
    $display("%0d scan steps hit a pattern, trie grown to %0d nodes.", match_steps,
             nodes_used);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end
endmodule
